// ===== sv/prsl_pkg.sv =====
// ----------------------------------------------------------------------------
// prsl_pkg: shared types and constants of the ring slope limiter
// Cell and neighbor-triple types, field widths and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package prsl_pkg;

    // Default parameter values
    localparam int DEFAULT_MAX_RING_CELLS = 4096;
    localparam int DEFAULT_FRAC_BITS      = 16;

    // Field widths
    localparam int VAL_W   = 32;   // cell value, signed
    localparam int WID_W   = 31;   // cell width, unsigned
    localparam int DIFF_W  = 33;   // difference of two values, and its magnitude
    localparam int DEN_W   = 33;   // up to four widths summed
    localparam int THETA_W = 5;
    localparam int POS_W   = 12;
    localparam int SLOPE_W = 32;

    // Stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;

    // Theta is held in eighths
    localparam int MM_SHIFT = 3;
    localparam logic [THETA_W-1:0] THETA_RESET = 5'd12;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [WID_W-1:0]        width;
    } t_cell;

    // Left neighbor, the cell itself, right neighbor
    typedef struct packed {
        t_cell left;
        t_cell centre;
        t_cell right;
    } t_triple;

endpackage

`default_nettype wire

// ===== sv/prsl_div.sv =====
// ----------------------------------------------------------------------------
// prsl_div: shared radix-2 restoring divider
// Divides a magnitude scaled by 2^(FRAC_BITS+1) by a width sum, one quotient
// bit per cycle. A zero divisor yields a zero quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module prsl_div #(
    parameter int FRAC_BITS = prsl_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [prsl_pkg::DIFF_W-1:0]  i_num,
    input  wire logic [prsl_pkg::DEN_W-1:0]   i_den,
    output logic                              o_done,
    output logic [prsl_pkg::DIFF_W+FRAC_BITS:0] o_quo
);

    localparam int QW    = prsl_pkg::DIFF_W + FRAC_BITS + 1;
    localparam int DEN_W = prsl_pkg::DEN_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [QW-1:0]    r_dvd;
    logic [QW-1:0]    r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_den_zero;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W+1:0] w_trial;
    logic             w_ge;

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_trial = {1'b0, r_rem, r_dvd[QW-1]} - {2'b00, r_den};
    assign w_ge    = !w_trial[DEN_W+1];

    // Iterate one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd      <= {i_num, {(FRAC_BITS + 1){1'b0}}};
            r_quo      <= '0;
            r_rem      <= '0;
            r_den      <= i_den;
            r_den_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[QW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], w_ge};
            if (w_ge) begin
                r_rem <= w_trial[DEN_W-1:0];
            end else begin
                r_rem <= {r_rem[DEN_W-2:0], r_dvd[QW-1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_den_zero ? '0 : r_quo;

endmodule

`default_nettype wire

// ===== sv/prsl_limit.sv =====
// ----------------------------------------------------------------------------
// prsl_limit: limited slope of one cell
// Runs the left, right and centered slopes through the shared divider,
// scales the side slopes by theta, takes the generalized minmod over two
// compare steps and saturates the result to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module prsl_limit #(
    parameter int FRAC_BITS = prsl_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire prsl_pkg::t_triple             i_cells,   // held for the whole run
    input  wire logic [prsl_pkg::THETA_W-1:0]  i_theta,
    output logic                               o_done,
    output logic signed [prsl_pkg::SLOPE_W-1:0] o_slope
);

    localparam int QW    = prsl_pkg::DIFF_W + FRAC_BITS + 1;
    localparam int TW    = prsl_pkg::THETA_W;
    localparam int PRW   = QW + TW;
    localparam int SH    = prsl_pkg::MM_SHIFT;
    localparam int QV_W  = PRW - SH;
    localparam int DW    = prsl_pkg::DIFF_W;
    localparam int DEN_W = prsl_pkg::DEN_W;
    localparam int VW    = prsl_pkg::VAL_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_MM1   = 3'd4;
    localparam logic [2:0] S_MM2   = 3'd5;
    localparam logic [2:0] S_SAT   = 3'd6;

    // Slope selectors
    localparam logic [1:0] SEL_L = 2'd0;
    localparam logic [1:0] SEL_R = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    logic [2:0]       r_state;
    logic [1:0]       r_sel;
    logic [DW-1:0]    r_diff;
    logic [DEN_W-1:0] r_den;
    logic [2:0]       r_sgn;
    logic [PRW-1:0]   r_mag [3];
    logic             r_m_sgn;
    logic [PRW-1:0]   r_m_mag;
    logic             r_done;
    logic signed [VW-1:0] r_slope;

    logic [VW-1:0]    w_x;
    logic [VW-1:0]    w_y;
    logic [DW-1:0]    w_diff;
    logic [DEN_W-1:0] w_den;
    logic [DW-1:0]    w_num;
    logic             w_div_done;
    logic [QW-1:0]    w_quo;
    logic [PRW-1:0]   w_prod;
    logic [PRW-1:0]   w_eight;

    logic             w_opp_ab;
    logic             w_opp_bc;
    logic [PRW-1:0]   w_base_mag;
    logic             w_base_sgn;
    logic [PRW-1:0]   w_cand_mag;
    logic             w_cand_sgn;
    logic [QV_W-1:0]  w_q8;
    logic             w_big;
    logic [VW-1:0]    w_sat;

    // Pick the difference and width sum of the current slope
    always_comb begin
        case (r_sel)
            SEL_L: begin
                w_x   = i_cells.centre.value;
                w_y   = i_cells.left.value;
                w_den = {2'b00, i_cells.left.width} + {2'b00, i_cells.centre.width};
            end
            SEL_R: begin
                w_x   = i_cells.right.value;
                w_y   = i_cells.centre.value;
                w_den = {2'b00, i_cells.right.width} + {2'b00, i_cells.centre.width};
            end
            default: begin
                w_x   = i_cells.right.value;
                w_y   = i_cells.left.value;
                w_den = {2'b00, i_cells.left.width} + {2'b00, i_cells.right.width}
                      + {1'b0, i_cells.centre.width, 1'b0};
            end
        endcase
    end

    assign w_diff = {w_x[VW-1], w_x} - {w_y[VW-1], w_y};
    assign w_num  = r_diff[DW-1] ? (DW'(0) - r_diff) : r_diff;

    prsl_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ISSUE),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Scale the quotient: theta for the side slopes, eight for the center one
    assign w_prod  = {{QW{1'b0}}, i_theta} * {{TW{1'b0}}, w_quo};
    assign w_eight = {{(TW - SH){1'b0}}, w_quo, {SH{1'b0}}};

    // Minmod operands: a is the left slope, b the center one, c the right one
    assign w_opp_ab = (r_mag[SEL_L] != '0) && (r_mag[SEL_C] != '0)
                   && (r_sgn[SEL_L] != r_sgn[SEL_C]);
    assign w_opp_bc = (r_mag[SEL_C] != '0) && (r_mag[SEL_R] != '0)
                   && (r_sgn[SEL_C] != r_sgn[SEL_R]);

    // One shared magnitude compare, used in both minmod steps
    always_comb begin
        if (r_state == S_MM1) begin
            w_base_mag = w_opp_ab ? '0 : r_mag[SEL_L];
            w_base_sgn = !w_opp_ab && r_sgn[SEL_L];
            w_cand_mag = r_mag[SEL_C];
            w_cand_sgn = r_sgn[SEL_C];
        end else begin
            w_base_mag = w_opp_bc ? '0 : r_m_mag;
            w_base_sgn = !w_opp_bc && r_m_sgn;
            w_cand_mag = r_mag[SEL_R];
            w_cand_sgn = r_sgn[SEL_R];
        end
    end

    // Drop the eighths, truncating toward zero, then saturate
    assign w_q8  = r_m_mag[PRW-1:SH];
    assign w_big = |w_q8[QV_W-1:VW-1];

    always_comb begin
        if (r_m_sgn) begin
            w_sat = w_big ? {1'b1, {(VW - 1){1'b0}}} : (VW'(0) - w_q8[VW-1:0]);
        end else begin
            w_sat = w_big ? {1'b0, {(VW - 1){1'b1}}} : w_q8[VW-1:0];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_L;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sel   <= SEL_L;
                        r_state <= S_PREP;
                    end
                end
                S_PREP:  r_state <= S_ISSUE;
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_div_done) begin
                        if (r_sel == SEL_C) begin
                            r_state <= S_MM1;
                        end else begin
                            r_sel   <= r_sel + 1'b1;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_MM1: r_state <= S_MM2;
                S_MM2: r_state <= S_SAT;
                S_SAT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_diff <= w_diff;
            r_den  <= w_den;
        end
        if ((r_state == S_WAIT) && w_div_done) begin
            r_sgn[r_sel] <= r_diff[DW-1];
            r_mag[r_sel] <= (r_sel == SEL_C) ? w_eight : w_prod;
        end
        if ((r_state == S_MM1) || (r_state == S_MM2)) begin
            if (w_cand_mag < w_base_mag) begin
                r_m_mag <= w_cand_mag;
                r_m_sgn <= w_cand_sgn;
            end else begin
                r_m_mag <= w_base_mag;
                r_m_sgn <= w_base_sgn;
            end
        end
        if (r_state == S_SAT) begin
            r_slope <= w_sat;
        end
    end

    assign o_done  = r_done;
    assign o_slope = r_slope;

endmodule

`default_nettype wire

// ===== sv/periodic_ring_plm_slope_limiter_top.sv =====
// Results: each computed result runs through the shared radix-2 divider, which yields one
//   quotient bit per cycle.
// Cells: one cell is in work at a time; a closing cell of a ring of three or more costs three
//   results, cells 0 and 1 of a ring need no division. Input and theta wait while a cell is in work.
// Reset: synchronous, active low; clears the sequencer, the ring count and the output
//   register, and loads theta with 12 (1.5). No clearing pass.
// ----------------------------------------------------------------------------
// periodic_ring_plm_slope_limiter_top: periodic ring PLM slope limiter
// Holds the first two and the two latest cells of a ring, forms the neighbor triples
// and emits the generalized-minmod slope of each cell, cell 0 last in rings of three or more.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_ring_plm_slope_limiter_top #(
    parameter int MAX_RING_CELLS = prsl_pkg::DEFAULT_MAX_RING_CELLS,
    parameter int FRAC_BITS      = prsl_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Cell input
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [prsl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // cell_value, cell_width
    input  wire logic                               s_axis_tlast,  // last_in_ring
    // Slope output
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [prsl_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // limited_slope, cell_position
    output logic                                    m_axis_tlast,  // last_of_ring
    // Theta write
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [prsl_pkg::THETA_W-1:0]       i_cfg_data
);

    localparam int CW    = (MAX_RING_CELLS > 2) ? $clog2(MAX_RING_CELLS) : 1;
    localparam int POS_W = prsl_pkg::POS_W;
    localparam int PW    = (CW > POS_W) ? CW : POS_W;
    localparam int VW    = prsl_pkg::VAL_W;
    localparam int WW    = prsl_pkg::WID_W;
    localparam int PAD_W = prsl_pkg::OUT_TDATA_W - prsl_pkg::SLOPE_W - POS_W;

    // Sequencer states
    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_START = 3'd1;
    localparam logic [2:0] T_WAIT  = 3'd2;
    localparam logic [2:0] T_EMIT  = 3'd3;
    localparam logic [2:0] T_FIN   = 3'd4;

    logic [2:0]                      r_state;
    logic [CW-1:0]                   r_cnt;
    logic [CW-1:0]                   r_k;
    logic                            r_big;
    logic [1:0]                      r_job;
    logic [1:0]                      r_njob;
    logic [prsl_pkg::THETA_W-1:0]    r_theta;
    prsl_pkg::t_cell                 r_first;
    prsl_pkg::t_cell                 r_second;
    prsl_pkg::t_cell                 r_older;
    prsl_pkg::t_cell                 r_newer;
    prsl_pkg::t_cell                 r_cur;
    logic                            r_cur_last;
    logic signed [VW-1:0]            r_res;
    logic                            r_out_valid;
    logic signed [VW-1:0]            r_out_slope;
    logic [POS_W-1:0]                r_out_pos;
    logic                            r_out_last;

    logic                            w_in_acc;
    prsl_pkg::t_cell                 w_in_cell;
    logic [1:0]                      w_njob;
    prsl_pkg::t_triple               w_triple;
    logic                            w_lim_done;
    logic signed [VW-1:0]            w_lim_slope;
    logic [PW-1:0]                   w_kx;
    logic [PW-1:0]                   w_km1;
    logic [POS_W-1:0]                w_pos;
    logic                            w_last_job;
    logic                            w_load;

    assign w_in_acc        = s_axis_tvalid && s_axis_tready;
    assign w_in_cell.value = s_axis_tdata[VW-1:0];
    assign w_in_cell.width = s_axis_tdata[VW+WW-1:VW];

    // Results owed by the incoming cell
    always_comb begin
        if ({1'b0, r_cnt} >= (CW + 1)'(2)) begin
            w_njob = s_axis_tlast ? 2'd3 : 2'd1;
        end else if (!s_axis_tlast) begin
            w_njob = 2'd0;
        end else begin
            w_njob = (r_cnt == CW'(1)) ? 2'd2 : 2'd1;
        end
    end

    // Neighbor triple of the current result
    always_comb begin
        case (r_job)
            2'd0:    w_triple = '{left: r_older, centre: r_newer, right: r_cur};
            2'd1:    w_triple = '{left: r_newer, centre: r_cur, right: r_first};
            default: w_triple = '{left: r_cur, centre: r_first, right: r_second};
        endcase
    end

    // Position of the current result
    assign w_kx  = PW'(r_k);
    assign w_km1 = w_kx - 1'b1;

    always_comb begin
        if (r_big) begin
            case (r_job)
                2'd0:    w_pos = w_km1[POS_W-1:0];
                2'd1:    w_pos = w_kx[POS_W-1:0];
                default: w_pos = '0;
            endcase
        end else begin
            w_pos = POS_W'(r_job);
        end
    end

    assign w_last_job = (r_job == (r_njob - 1'b1));
    assign w_load     = (r_state == T_EMIT) && (!r_out_valid || m_axis_tready);

    prsl_limit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_limit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == T_START) && r_big),
        .i_cells (w_triple),
        .i_theta (r_theta),
        .o_done  (w_lim_done),
        .o_slope (w_lim_slope)
    );

    // Sequencer over the results of one cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_job   <= '0;
            r_njob  <= '0;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (w_in_acc) begin
                        r_job   <= '0;
                        r_njob  <= w_njob;
                        r_state <= (w_njob == 2'd0) ? T_FIN : T_START;
                    end
                end
                T_START: r_state <= r_big ? T_WAIT : T_EMIT;
                T_WAIT: begin
                    if (w_lim_done) begin
                        r_state <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (w_load) begin
                        if (w_last_job) begin
                            r_state <= T_FIN;
                        end else begin
                            r_job   <= r_job + 1'b1;
                            r_state <= T_START;
                        end
                    end
                end
                T_FIN:   r_state <= T_IDLE;
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // Capture the cell and its place in the ring
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cur      <= w_in_cell;
            r_cur_last <= s_axis_tlast;
            r_k        <= r_cnt;
            r_big      <= ({1'b0, r_cnt} >= (CW + 1)'(2));
        end
        if (r_state == T_START) begin
            r_res <= '0;
        end else if ((r_state == T_WAIT) && w_lim_done) begin
            r_res <= w_lim_slope;
        end
    end

    // Advance the ring state once the cell's results are out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_older  <= '0;
            r_newer  <= '0;
        end else if (r_state == T_FIN) begin
            if (r_k == '0) begin
                r_first <= r_cur;
            end
            if (r_k == CW'(1)) begin
                r_second <= r_cur;
            end
            if (r_cur_last) begin
                r_cnt <= '0;
            end else begin
                r_older <= r_newer;
                r_newer <= r_cur;
                if (r_k != CW'(MAX_RING_CELLS - 1)) begin
                    r_cnt <= r_k + 1'b1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_slope <= r_res;
            r_out_pos   <= w_pos;
            r_out_last  <= r_cur_last && w_last_job;
        end
    end

    // Theta register, written on a transfer while no cell is in work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta <= prsl_pkg::THETA_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_theta <= i_cfg_data;
        end
    end

    assign s_axis_tready = (r_state == T_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_pos, r_out_slope};
    assign m_axis_tlast  = r_out_last;
    assign o_cfg_ready   = (r_state == T_IDLE);

endmodule

`default_nettype wire

// ===== sv/prsl_checker.sv =====
// ----------------------------------------------------------------------------
// prsl_checker: port-level checks of the ring slope limiter
// Watches the top level's ports and flags handshake and framing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module prsl_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [prsl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                              m_axis_tlast
);

    localparam int SW = prsl_pkg::SLOPE_W;
    localparam int PW = prsl_pkg::POS_W;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Drop ready for the cycle after a cell transfer
    a_busy_after_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a cell transfer");

    // Keep the padding bits of the result clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[prsl_pkg::OUT_TDATA_W-1:SW+PW] == '0))
        else $error("result padding not zero");

    // Close a ring at position 0 or, for a two-cell ring, position 1
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[SW+PW-1:SW] == PW'(0)) || (m_axis_tdata[SW+PW-1:SW] == PW'(1)))
        else $error("ring closed at an unexpected position");

endmodule

bind periodic_ring_plm_slope_limiter_top prsl_checker u_prsl_checker (.*);

`default_nettype wire
